@@ sv/sspp_pkg.sv @@
// shared constants, types and control structs of the segment speed planner
`default_nettype none
package sspp_pkg;
    localparam int STEPPER_COUNT = 4;
    localparam int SLOTS = 4;
    localparam int NUM_W = 48;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [31:0] INIT_TIME = 32'd167772;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    localparam logic [1:0] CASE_TARGET = 2'd0;
    localparam logic [1:0] CASE_WMAX = 2'd1;
    localparam logic [1:0] CASE_WMIN = 2'd2;
    localparam logic [1:0] CASE_JERK = 2'd3;

    typedef enum logic [1:0] {
        DIV_MAX = 2'd0,
        DIV_MIN = 2'd1,
        DIV_SPD = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic        mul;
        logic        start;
        div_sel_t    which;
        logic        chk;
        logic        adj;
        logic [31:0] prev_time;
        logic [31:0] seg_time;
        logic [31:0] delta;
    } lane_ctl_t;

    typedef struct packed {
        logic        done;
        logic        has_max;
        logic [31:0] max_t;
        logic [31:0] min_t;
        logic        brake;
        logic [31:0] rem;
    } lane_res_t;
endpackage
`default_nettype wire

@@ sv/stepper_segment_speed_planner.sv @@
// top level of the four-stepper segment speed planner
//
// channel  dir  fields (lowest bit first)
// s_axis   in   tuser: command; tdata: segment_length, target_speed, jerk_flag,
//               step_dist_0..3, stepper_select, end_delta
// m_axis   out  tdata: segment_time, time_case, braking, end_distance_out
// cfg      in   cfg_we, cfg_index, cfg_data
//
// a plan item runs three serial 48-step divisions per lane (window max, window
// min, new speed) between its control states; with the jerk flag set the
// window-min division is skipped
// an adjust item goes through the adjust state to the output; one item is in work at a time
// reset clears speeds, end distances, config registers and the pending flag
// a finished item waits while the output register still holds an untaken result
`default_nettype none
module stepper_segment_speed_planner (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [183:0] s_axis_tdata, // segment_length, target_speed, jerk_flag,
                                            // step_dist_0..3, stepper_select, end_delta
    input  wire logic         s_axis_tuser, // command
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [71:0]       m_axis_tdata, // segment_time, time_case, braking,
                                            // end_distance_out
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [23:0]  cfg_data
);
    import sspp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ADJ, S_MUL, S_DMAX, S_WMAX, S_DMIN, S_WMIN, S_PICK,
        S_DSPD, S_WSPD, S_CHK, S_CHK2, S_CHK3, S_FIN
    } state_t;

    state_t      state_reg;
    logic [23:0] accel_reg [SLOTS];
    logic [23:0] top_reg [SLOTS];
    logic [31:0] prev_time_reg;
    logic        decel_reg;
    logic [23:0] seg_reg;
    logic [23:0] tgt_reg;
    logic        jerk_reg;
    logic [23:0] dist_reg [SLOTS];
    logic [1:0]  sel_reg;
    logic [31:0] delta_reg;
    logic [31:0] reg_time_reg;
    logic [31:0] new_time_reg;
    logic [1:0]  case_reg;
    logic [31:0] end_reg;
    logic        out_valid_reg;
    logic [71:0] out_data_reg;

    lane_ctl_t   ctl [SLOTS];
    lane_res_t   res [SLOTS];
    logic        mul_p;
    logic        start_p;
    div_sel_t    which;
    logic        chk_p;
    logic        adj_p;
    logic        rdone;
    logic [31:0] rquo;
    logic [31:0] m_time;
    logic [1:0]  m_case;
    logic        m_clear;
    logic        any_brake;
    logic        fin_load;

    always_comb
    begin
        mul_p = state_reg == S_MUL;
        start_p = (state_reg == S_DMAX) || (state_reg == S_DMIN) || (state_reg == S_DSPD);
        chk_p = state_reg == S_CHK;
        adj_p = state_reg == S_ADJ;
        case (state_reg)
            S_DMIN:  which = DIV_MIN;
            S_DSPD:  which = DIV_SPD;
            default: which = DIV_MAX;
        endcase
        any_brake = 1'b0;
        for (int i = 0; i < STEPPER_COUNT; i++)
        begin
            any_brake = any_brake | res[i].brake;
        end
    end

    assign fin_load = (state_reg == S_FIN) && (!out_valid_reg || m_axis_tready);

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_lane
        assign ctl[g] = '{mul: mul_p, start: start_p, which: which, chk: chk_p,
                          adj: adj_p && (sel_reg == 2'(g)), prev_time: prev_time_reg,
                          seg_time: new_time_reg, delta: delta_reg};
        if (g < STEPPER_COUNT)
        begin : g_on
            sspp_lane u_lane (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl[g]),
                .step_len (dist_reg[g]),
                .accel    (accel_reg[g]),
                .top      (top_reg[g]),
                .res      (res[g])
            );
        end
        else
        begin : g_off
            assign res[g] = '0;
        end
    end

    sspp_div u_rdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_DMAX),
        .num   ({seg_reg, 24'd0}),
        .den   ({8'd0, tgt_reg}),
        .done  (rdone),
        .quo   (rquo)
    );

    sspp_merge u_merge (
        .res         (res),
        .reg_time    (reg_time_reg),
        .decel       (decel_reg),
        .jerk        (jerk_reg),
        .pick_time   (m_time),
        .time_case   (m_case),
        .clear_decel (m_clear)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_time_reg <= INIT_TIME;
            decel_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                accel_reg[i] <= '0;
                top_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (!cfg_index[2])
                begin
                    accel_reg[cfg_index[1:0]] <= cfg_data;
                end
                else
                begin
                    top_reg[cfg_index[1:0]] <= cfg_data;
                end
            end
            if (fin_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        state_reg <= s_axis_tuser ? S_ADJ : S_MUL;
                    end
                end
                S_ADJ:
                begin
                    state_reg <= S_FIN;
                end
                S_MUL:
                begin
                    state_reg <= S_DMAX;
                end
                S_DMAX:
                begin
                    state_reg <= S_WMAX;
                end
                S_WMAX:
                begin
                    if (rdone)
                    begin
                        state_reg <= jerk_reg ? S_PICK : S_DMIN;
                    end
                end
                S_DMIN:
                begin
                    state_reg <= S_WMIN;
                end
                S_WMIN:
                begin
                    if (res[0].done)
                    begin
                        state_reg <= S_PICK;
                    end
                end
                S_PICK:
                begin
                    prev_time_reg <= m_time;
                    if (m_clear)
                    begin
                        decel_reg <= 1'b0;
                    end
                    state_reg <= S_DSPD;
                end
                S_DSPD:
                begin
                    state_reg <= S_WSPD;
                end
                S_WSPD:
                begin
                    if (res[0].done)
                    begin
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    state_reg <= S_CHK2;
                end
                S_CHK2:
                begin
                    state_reg <= S_CHK3;
                end
                S_CHK3:
                begin
                    decel_reg <= decel_reg | any_brake;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (fin_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && s_axis_tvalid)
        begin
            seg_reg   <= s_axis_tdata[23:0];
            tgt_reg   <= s_axis_tdata[47:24];
            jerk_reg  <= s_axis_tdata[48];
            dist_reg[0] <= s_axis_tdata[72:49];
            dist_reg[1] <= s_axis_tdata[96:73];
            dist_reg[2] <= s_axis_tdata[120:97];
            dist_reg[3] <= s_axis_tdata[144:121];
            sel_reg   <= s_axis_tdata[146:145];
            delta_reg <= s_axis_tdata[178:147];
        end
        if (state_reg == S_ADJ)
        begin
            new_time_reg <= '0;
            case_reg     <= CASE_TARGET;
            end_reg      <= (32'(sel_reg) < 32'(STEPPER_COUNT)) ?
                            (res[sel_reg].rem + delta_reg) : 32'd0;
        end
        if (rdone)
        begin
            reg_time_reg <= rquo;
        end
        if (state_reg == S_PICK)
        begin
            new_time_reg <= m_time;
            case_reg     <= m_case;
            end_reg      <= '0;
        end
        if (fin_load)
        begin
            out_data_reg <= {5'd0, end_reg, decel_reg, case_reg, new_time_reg};
        end
    end

    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
endmodule
`default_nettype wire

@@ sv/sspp_div.sv @@
// serial restoring divider, one quotient bit a cycle, saturating to 32 bits
`default_nettype none
module sspp_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [sspp_pkg::NUM_W-1:0] num,
    input  wire logic [31:0]               den,
    output logic                           done,
    output logic [31:0]                    quo
);
    import sspp_pkg::*;

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] q_reg;
    logic [32:0]      rem_reg;
    logic [31:0]      den_reg;
    logic [32:0]      rem_sh;
    logic             ge;

    assign rem_sh = {rem_reg[31:0], num_reg[NUM_W-1]};
    assign ge = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            q_reg   <= {q_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo = ((den_reg == '0) || (q_reg[NUM_W-1:32] != '0)) ? MAX32 : q_reg[31:0];
endmodule
`default_nettype wire

@@ sv/sspp_lane.sv @@
// one stepper lane: speed window, new speed, braking test and end distance
`default_nettype none
module sspp_lane (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sspp_pkg::lane_ctl_t   ctl,
    input  wire logic [23:0]           step_len,
    input  wire logic [23:0]           accel,
    input  wire logic [23:0]           top,
    output sspp_pkg::lane_res_t        res
);
    import sspp_pkg::*;

    logic [31:0] speed_reg;
    logic [31:0] rem_reg;
    logic [39:0] dv_reg;
    logic        has_max_reg;
    logic [31:0] max_t_reg;
    logic [31:0] min_t_reg;
    logic [63:0] vsq_reg;
    logic [57:0] lim_reg;
    logic        brake_reg;
    div_sel_t    which_reg;

    logic [55:0] prod;
    logic [40:0] fast;
    logic [31:0] den;
    logic [31:0] abs_e;
    logic        dv_done;
    logic [31:0] quo;

    assign prod = {32'd0, accel} * {24'd0, ctl.prev_time};
    assign fast = {9'd0, speed_reg} + {1'b0, dv_reg};
    assign abs_e = rem_reg[31] ? (32'd0 - rem_reg) : rem_reg;

    always_comb
    begin
        case (ctl.which)
            DIV_MAX: den = 32'({8'd0, speed_reg} - dv_reg);
            DIV_MIN: den = (fast > {17'd0, top}) ? {8'd0, top} : fast[31:0];
            DIV_SPD: den = ctl.seg_time;
            default: den = ctl.seg_time;
        endcase
    end

    sspp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.start),
        .num   ({step_len, 24'd0}),
        .den   (den),
        .done  (dv_done),
        .quo   (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            if (dv_done && (which_reg == DIV_SPD))
            begin
                speed_reg <= quo;
            end
            if (ctl.adj)
            begin
                rem_reg <= rem_reg + ctl.delta;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            dv_reg <= prod[55:16];
        end
        if (ctl.start)
        begin
            which_reg <= ctl.which;
            if (ctl.which == DIV_MAX)
            begin
                has_max_reg <= {8'd0, speed_reg} > dv_reg;
            end
        end
        if (dv_done)
        begin
            case (which_reg)
                DIV_MAX: max_t_reg <= quo;
                DIV_MIN: min_t_reg <= quo;
                default: ;
            endcase
        end
        if (ctl.chk)
        begin
            vsq_reg <= {32'd0, speed_reg} * {32'd0, speed_reg};
            lim_reg <= 58'({34'd0, accel} * {25'd0, ({1'b0, abs_e} + 33'd1)}) << 1;
        end
        brake_reg <= (lim_reg[57:48] == '0) && (vsq_reg >= {lim_reg[47:0], 16'd0});
    end

    assign res.done = dv_done;
    assign res.has_max = has_max_reg;
    assign res.max_t = max_t_reg;
    assign res.min_t = min_t_reg;
    assign res.brake = brake_reg;
    assign res.rem = rem_reg;
endmodule
`default_nettype wire

@@ sv/sspp_merge.sv @@
// merges lane windows into the segment time and its case
`default_nettype none
module sspp_merge (
    input  wire sspp_pkg::lane_res_t res [sspp_pkg::SLOTS],
    input  wire logic [31:0]         reg_time,
    input  wire logic                decel,
    input  wire logic                jerk,
    output logic [31:0]              pick_time,
    output logic [1:0]               time_case,
    output logic                     clear_decel
);
    import sspp_pkg::*;

    logic        has_max;
    logic [31:0] max_t;
    logic [31:0] min_t;
    logic [31:0] max_adj;

    always_comb
    begin
        has_max = 1'b0;
        max_t = '0;
        min_t = '0;
        for (int i = 0; i < STEPPER_COUNT; i++)
        begin
            if (res[i].has_max)
            begin
                if (!has_max || (res[i].max_t < max_t))
                begin
                    max_t = res[i].max_t;
                end
                has_max = 1'b1;
            end
            if (res[i].min_t > min_t)
            begin
                min_t = res[i].min_t;
            end
        end
        max_adj = (max_t < min_t) ? min_t : max_t;
        clear_decel = 1'b0;
        if (jerk)
        begin
            pick_time = reg_time;
            time_case = CASE_JERK;
        end
        else if (has_max && (decel || (reg_time > max_adj)))
        begin
            pick_time = max_adj;
            time_case = CASE_WMAX;
            clear_decel = 1'b1;
        end
        else if (reg_time < min_t)
        begin
            pick_time = min_t;
            time_case = CASE_WMIN;
        end
        else
        begin
            pick_time = reg_time;
            time_case = CASE_TARGET;
        end
    end
endmodule
`default_nettype wire
